>>> sv/hec_pkg.sv
// Package for the Hamming encode/correct block: field widths and the
// constant helpers for code layout and length clamping. No dependencies.
`timescale 1ns / 1ps

package hec_pkg;

    localparam int DATA_W  = 32;   // data_in / code_out width
    localparam int LEN_W   = 5;    // msg_len width
    localparam int PAR_W   = 3;    // parity_count width
    localparam int SYN_W   = 5;    // syndrome width
    localparam int NUM_W   = 6;    // codeword length n, up to 32
    localparam int RESET_LEN = 4;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    // Smallest r with 2^r >= len + r + 1, for len in 1..31
    function automatic logic [PAR_W-1:0] parity_for(input logic [LEN_W-1:0] len);
        logic [PAR_W-1:0] r;
        if (len <= 5'd1)       r = 3'd2;
        else if (len <= 5'd4)  r = 3'd3;
        else if (len <= 5'd11) r = 3'd4;
        else if (len <= 5'd26) r = 3'd5;
        else                   r = 3'd6;
        return r;
    endfunction

    // Effective message length: zero reads as one, then the largest length
    // not above the request whose codeword fits within cap bits.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] req,
                                                 input int unsigned cap);
        logic [LEN_W-1:0] best;
        logic [LEN_W-1:0] want;
        logic [LEN_W-1:0] l;
        best = 5'd1;
        want = (req == '0) ? 5'd1 : req;
        for (int k = 1; k < 32; k++) begin
            l = LEN_W'(k);
            if (l <= want && (k + int'(parity_for(l))) <= int'(cap))
                best = l;
        end
        return best;
    endfunction

    function automatic bit is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    function automatic int flog2(input int p);
        int r;
        r = 0;
        for (int k = 0; k < 8; k++)
            if ((p >> (k + 1)) != 0) r = k + 1;
        return r;
    endfunction

    // Message bit that lands at data position p (non-power-of-two)
    function automatic int data_index(input int p);
        return p - flog2(p) - 2;
    endfunction

    // Positions covered by parity bit i, position p at bit p-1
    function automatic logic [DATA_W-1:0] group_mask(input int i);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int j = 0; j < DATA_W; j++)
            m[j] = (((j + 1) >> i) & 1) != 0;
        return m;
    endfunction

endpackage

>>> sv/hamming_encode_correct.sv
// Hamming SEC encoder / checker-corrector with configurable message length.
// Pipeline: four register stages (input, layout, syndrome, output); m_tvalid is registered.
// Throughput: one item per cycle; each stage holds only while the stage after it is full
// and stalled, and empty stages fill in behind a stall.
// Reset (aresetn low, synchronous): pipeline emptied, msg_len back to 4 (clamped to fit).
// Depends on hec_pkg.
`timescale 1ns / 1ps

module hamming_encode_correct #(
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: msg_len
    input  logic                          cfg_we,
    input  logic [hec_pkg::LEN_W-1:0]     cfg_wdata,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] data_in
    input  logic                          s_tuser,   // [0] op
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [31:0] code_out, [34:32] parity_count,
                                                     // [39:35] syndrome
    output logic                          m_tuser    // [0] bad_syndrome
);
    import hec_pkg::*;

    localparam int unsigned CAP = (MAX_CODE_BITS > DATA_W) ? DATA_W : MAX_CODE_BITS;
    localparam logic [LEN_W-1:0] RST_LEN = eff_len(LEN_W'(RESET_LEN), CAP);
    localparam logic [PAR_W-1:0] RST_PAR = parity_for(RST_LEN);
    localparam logic [NUM_W-1:0] RST_N   = NUM_W'(RST_LEN) + NUM_W'(RST_PAR);

    // ---------------- configuration: derived code geometry ----------------
    logic [PAR_W-1:0]  par_reg,  par_next;
    logic [NUM_W-1:0]  n_reg,    n_next;
    logic [DATA_W-1:0] mask_reg, mask_next;
    logic [LEN_W-1:0]  len_next;

    always_comb begin
        len_next = eff_len(cfg_wdata, CAP);
        par_next = parity_for(len_next);
        n_next   = NUM_W'(len_next) + NUM_W'(par_next);
        for (int j = 0; j < DATA_W; j++)
            mask_next[j] = (NUM_W'(j) < n_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            par_reg <= RST_PAR;
            n_reg   <= RST_N;
            for (int j = 0; j < DATA_W; j++)
                mask_reg[j] <= (NUM_W'(j) < RST_N);
        end else if (cfg_we) begin
            par_reg  <= par_next;
            n_reg    <= n_next;
            mask_reg <= mask_next;
        end
    end

    // ---------------- pipeline handshake ----------------
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy_o;

    assign rdy_o    = !vo_reg || m_tready;
    assign rdy3     = !v3_reg || rdy_o;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1)  v1_reg <= s_tvalid;
            if (rdy2)  v2_reg <= v1_reg;
            if (rdy3)  v3_reg <= v2_reg;
            if (rdy_o) vo_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic              op1_reg;
    logic [DATA_W-1:0] data1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            op1_reg   <= s_tuser;
            data1_reg <= s_tdata;
        end
    end

    // ---------------- stage 2: codeword layout ----------------
    // encode scatters message bits over the data positions; both ops mask to n
    logic [DATA_W-1:0] scat;
    logic              op2_reg;
    logic [DATA_W-1:0] word2_reg, word2_next;

    for (genvar p = 1; p <= DATA_W; p++) begin : g_scat
        if (is_pow2(p)) begin : g_par
            assign scat[p-1] = 1'b0;
        end else begin : g_dat
            localparam int K = data_index(p);
            assign scat[p-1] = data1_reg[K];
        end
    end

    assign word2_next = ((op1_reg == OP_ENCODE) ? scat : data1_reg) & mask_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            op2_reg   <= op1_reg;
            word2_reg <= word2_next;
        end
    end

    // ---------------- stage 3: syndrome ----------------
    logic              op3_reg;
    logic [DATA_W-1:0] word3_reg;
    logic [SYN_W-1:0]  syn3_reg, syn3_next;

    always_comb begin
        for (int i = 0; i < SYN_W; i++)
            syn3_next[i] = ^(word2_reg & group_mask(i));
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            op3_reg   <= op2_reg;
            word3_reg <= word2_reg;
            syn3_reg  <= syn3_next;
        end
    end

    // ---------------- stage 4: parity insert / correction ----------------
    logic              opo_reg;
    logic [DATA_W-1:0] code_reg, code_next;
    logic [SYN_W-1:0]  syn_reg,  syn_next;
    logic              bad_reg,  bad_next;
    logic [DATA_W-1:0] with_par;
    logic              syn_big;

    assign syn_big = NUM_W'(syn3_reg) > n_reg;

    always_comb begin
        // parity bit i sits at position 2^i; higher syndrome bits are zero on encode
        with_par = word3_reg;
        for (int i = 0; i < SYN_W; i++)
            with_par[(1 << i) - 1] = syn3_reg[i];

        if (op3_reg == OP_ENCODE) begin
            code_next = with_par;
            syn_next  = '0;
            bad_next  = 1'b0;
        end else begin
            syn_next = syn3_reg;
            bad_next = syn_big;
            if (!syn_big && syn3_reg != '0)
                code_next = word3_reg ^ (DATA_W'(1) << (syn3_reg - SYN_W'(1)));
            else
                code_next = word3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_o) begin
            opo_reg  <= op3_reg;
            code_reg <= code_next;
            syn_reg  <= syn_next;
            bad_reg  <= bad_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {syn_reg, par_reg, code_reg};
    assign m_tuser  = bad_reg;

    // ---------------- assertions ----------------
    a_code_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg |-> (code_reg & ~mask_reg) == '0)
        else $error("code_out has bits beyond the codeword length");

    a_encode_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (vo_reg && opo_reg == OP_ENCODE) |-> (syn_reg == '0 && !bad_reg))
        else $error("encode result carries a syndrome or error flag");

    a_bad_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (vo_reg && bad_reg) |-> (opo_reg == OP_CHECK && syn_reg != '0))
        else $error("bad syndrome flagged without a nonzero check syndrome");

endmodule

>>> tb/sv/hamming_result_checker.sv
// Result checker for the Hamming encode/correct block: watches the config port
// and both stream channels, predicts each result and compares it field by field.
// Depends on hec_pkg.
`timescale 1ns / 1ps

module hamming_result_checker #(
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [hec_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [31:0]               s_tdata,    // [31:0] data_in
    input  logic                      s_tuser,    // [0] op
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [39:0]               m_tdata,    // [31:0] code_out, [34:32] parity_count,
                                                  // [39:35] syndrome
    input  logic                      m_tuser,    // [0] bad_syndrome
    output int                        pending,
    output int                        fail_count,
    output int                        results_seen,
    output int                        fixed_seen,
    output int                        bad_seen
);

    import hec_pkg::*;

    localparam int CODE_CAP = (MAX_CODE_BITS > DATA_W) ? DATA_W : MAX_CODE_BITS;
    localparam int REPORT_MAX = 20;

    typedef struct packed {
        logic [DATA_W-1:0] code;
        logic [PAR_W-1:0]  parity_count;
        logic [SYN_W-1:0]  syndrome;
        logic              bad;
    } codeword_result_t;

    codeword_result_t expected_codes[$];
    logic [LEN_W-1:0] msg_len_q;
    int               accepted_in;
    int               accepted_out;

    assign pending = accepted_in - accepted_out;

    // Smallest parity count covering a message of len bits
    function automatic int parity_bits(input int len);
        int r;
        r = 0;
        while ((1 << r) < len + r + 1)
            r++;
        return r;
    endfunction

    // Even-parity syndrome over positions 1..n
    function automatic logic [SYN_W-1:0] code_syndrome(input logic [DATA_W-1:0] word,
                                                       input int n, input int r);
        logic [SYN_W-1:0] syn;
        syn = '0;
        for (int i = 0; i < r; i++)
            for (int p = 1; p <= n; p++)
                if ((p >> i) & 1)
                    syn[i] = syn[i] ^ word[p-1];
        return syn;
    endfunction

    function automatic codeword_result_t predict_codeword(input logic op,
                                                          input logic [DATA_W-1:0] data,
                                                          input logic [LEN_W-1:0] len_reg);
        codeword_result_t res;
        int len, r, n, src;
        logic [DATA_W-1:0] mask, word;
        logic [SYN_W-1:0] syn;
        len = (len_reg == '0) ? 1 : int'(len_reg);
        r = parity_bits(len);
        // shorten the message until the codeword fits
        while (len > 1 && len + r > CODE_CAP) begin
            len--;
            r = parity_bits(len);
        end
        n = len + r;
        mask = (n >= DATA_W) ? '1 : ((32'd1 << n) - 32'd1);
        res.bad = 1'b0;
        if (op == OP_ENCODE) begin
            word = '0;
            src = len;
            for (int p = n; p >= 1; p--) begin
                if ((p & (p - 1)) != 0) begin
                    src--;
                    word[p-1] = data[src];
                end
            end
            syn = code_syndrome(word, n, r);
            for (int i = 0; i < r; i++)
                word[(1 << i) - 1] = syn[i];
            syn = '0;
        end else begin
            word = data & mask;
            syn = code_syndrome(word, n, r);
            if (int'(syn) > n)
                res.bad = 1'b1;
            else if (syn != '0)
                word[syn-1] = ~word[syn-1];
        end
        res.code = word & mask;
        res.parity_count = PAR_W'(r);
        res.syndrome = syn;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < REPORT_MAX)
            $display("%0t ns  mismatch %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        results_seen = 0;
        fixed_seen = 0;
        bad_seen = 0;
    end

    // Prediction on input transfers, comparison on result transfers
    always @(posedge aclk) begin : track
        codeword_result_t got;
        codeword_result_t want;
        if (!aresetn) begin
            msg_len_q = LEN_W'(RESET_LEN);
            expected_codes.delete();
            accepted_in <= 0;
            accepted_out <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_codes.push_back(predict_codeword(s_tuser, s_tdata, msg_len_q));
                accepted_in <= accepted_in + 1;
            end
            if (m_tvalid && m_tready) begin
                accepted_out <= accepted_out + 1;
                results_seen++;
                got.code = m_tdata[31:0];
                got.parity_count = m_tdata[34:32];
                got.syndrome = m_tdata[39:35];
                got.bad = m_tuser;
                if (got.bad)
                    bad_seen++;
                else if (got.syndrome != '0)
                    fixed_seen++;
                if (expected_codes.size() == 0) begin
                    report_mismatch("unexpected result, code_out", '0, got.code);
                end else begin
                    want = expected_codes.pop_front();
                    if (got.code !== want.code)
                        report_mismatch("code_out", want.code, got.code);
                    if (got.parity_count !== want.parity_count)
                        report_mismatch("parity_count", 32'(want.parity_count),
                                        32'(got.parity_count));
                    if (got.syndrome !== want.syndrome)
                        report_mismatch("syndrome", 32'(want.syndrome), 32'(got.syndrome));
                    if (got.bad !== want.bad)
                        report_mismatch("bad_syndrome", 32'(want.bad), 32'(got.bad));
                end
            end
            if (cfg_we)
                msg_len_q = cfg_wdata;
        end
    end

endmodule

>>> tb/sv/tb_hamming_encode_correct.sv
// Testbench top for hamming_encode_correct: clock, reset, stimulus, ready
// stalls, watchdog and verdict. Depends on hec_pkg and hamming_result_checker.
`timescale 1ns / 1ps

module tb_hamming_encode_correct;

    import hec_pkg::*;

    localparam int QUIET_LIMIT = 400;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 140;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [LEN_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;
    logic                 m_tuser;

    int  pending;
    int  fail_count;
    int  results_seen;
    int  fixed_seen;
    int  bad_seen;
    int  encodes_sent;
    int  checks_sent;
    int  quiet_cycles;
    bit  tx_burst;
    bit  rx_burst;

    hamming_encode_correct #(
        .MAX_CODE_BITS(32)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    hamming_result_checker #(
        .MAX_CODE_BITS(32)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .pending      (pending),
        .fail_count   (fail_count),
        .results_seen (results_seen),
        .fixed_seen   (fixed_seen),
        .bad_seen     (bad_seen)
    );

    // 8 ns clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // One codeword transfer, after a random gap unless in burst mode
    task automatic send_word(input logic op, input logic [31:0] data);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_ENCODE)
            encodes_sent++;
        else
            checks_sent++;
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] len);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        logic        op;
        logic [31:0] data;
        for (int k = 0; k < count; k++) begin
            op = $urandom_range(0, 1) ? OP_CHECK : OP_ENCODE;
            data = $urandom;
            // some words cleared above a random bit, so zero syndromes show up often
            if ($urandom_range(0, 3) == 0)
                data = data & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
            send_word(op, data);
            if (k == count / 2)
                drain_results();
        end
    endtask

    // Result-side stalls
    initial begin : rx_side
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("** hamming_encode_correct: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        logic [LEN_W-1:0] phase_len[9];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        encodes_sent = 0;
        checks_sent = 0;
        quiet_cycles = 0;
        phase_len = '{5'd1, 5'd26, 5'd0, 5'd31, 5'd27, 5'd3, 5'd12, 5'd11, 5'd2};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset length 4, codeword of 7 bits
        send_word(OP_ENCODE, 32'h0000_0000);
        send_word(OP_ENCODE, 32'hFFFF_FFFF);
        send_word(OP_CHECK, 32'h0000_0000);
        send_word(OP_CHECK, 32'h0000_007F);
        send_word(OP_CHECK, 32'h0000_0077);
        send_word(OP_CHECK, 32'hFFFF_FFFF);
        // zero length reads as one
        write_len(5'd0);
        send_word(OP_ENCODE, 32'h0000_0001);
        send_word(OP_CHECK, 32'h0000_0007);
        send_word(OP_CHECK, 32'h0000_0004);
        // n = 5: syndrome 7 lies beyond the codeword
        write_len(5'd2);
        send_word(OP_CHECK, 32'h0000_000C);
        send_word(OP_CHECK, 32'h0000_0008);
        send_word(OP_ENCODE, 32'h0000_0003);
        // longest codeword, error at the top position
        write_len(5'd26);
        send_word(OP_ENCODE, 32'h03FF_FFFF);
        send_word(OP_ENCODE, 32'hFFFF_FFFF);
        send_word(OP_CHECK, 32'h7FFF_FFFF);
        send_word(OP_CHECK, 32'h4000_0000);
        // oversized length is clamped
        write_len(5'd31);
        send_word(OP_ENCODE, 32'hFFFF_FFFF);
        send_word(OP_CHECK, 32'hFFFF_FFFF);
        send_word(OP_CHECK, 32'h8000_0000);
        // n = 9: syndrome 14 beyond the codeword
        write_len(5'd5);
        send_word(OP_CHECK, 32'h0000_008A);
        send_word(OP_ENCODE, 32'h0000_001F);

        // Random phases over a spread of lengths, extremes first
        for (int ph = 0; ph < PHASES; ph++) begin
            write_len(ph < 9 ? phase_len[ph] : LEN_W'($urandom_range(0, 31)));
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            run_random(PHASE_ITEMS);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;

        drain_results();
        repeat (12) @(posedge aclk);
        $display("sent %0d encodes and %0d checks over %0d length settings (0..31 incl. clamped)",
                 encodes_sent, checks_sent, PHASES + 6);
        $display("got %0d results: %0d single-bit corrections, %0d out-of-range syndromes",
                 results_seen, fixed_seen, bad_seen);
        if (fail_count == 0)
            $display("** hamming_encode_correct: PASSED **");
        else
            $display("** hamming_encode_correct: FAILED **");
        $finish;
    end

endmodule
